@@ design/ttw_pkg.sv @@
// ----------------------------------------------------------------------------
// ttw_pkg
// Shared types, codes and defaults of the text terminal writer.
// ----------------------------------------------------------------------------
package ttw_pkg;

	localparam int DEF_COLS = 80;
	localparam int DEF_ROWS = 25;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0] ATTR_RESET = 8'h07;

	// register index taken from paddr[2]
	localparam logic REG_ATTR = 1'b0;

	localparam logic [1:0] FUNC_PUT   = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;
	// unused selector, reports the cursor and changes nothing
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
		logic        last_of_write;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_linear;
		logic        cursor_update;
		logic        scrolled;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
	} out_item_t;

	typedef struct packed {
		logic take;
		logic put;
		logic sweep;
		logic clear_start;
		logic capture;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       scroll_req;
		logic       sweep_last;
		logic       out_free;
	} status_t;

endpackage

@@ design/ttw_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttw_ctrl
// Sequencer of the text terminal writer: accepts items, runs puts, reads,
// scroll and clear sweeps, and hands results to the output register.
// ----------------------------------------------------------------------------
module ttw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ttw_pkg::status_t status,
	output ttw_pkg::cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_EXEC   = 7'b0000100,
		ST_SCROLL = 7'b0001000,
		ST_CLEAR  = 7'b0010000,
		ST_READ   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (status.func)
					ttw_pkg::FUNC_PUT: begin
						cmd.put = 1'b1;
						state_d = status.scroll_req ? ST_SCROLL : ST_DONE;
					end
					ttw_pkg::FUNC_READ: begin
						state_d = ST_READ;
					end
					ttw_pkg::FUNC_CLEAR: begin
						cmd.clear_start = 1'b1;
						state_d         = ST_CLEAR;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_SCROLL, ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				cmd.capture = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

@@ design/ttw_dp.sv @@
// ----------------------------------------------------------------------------
// ttw_dp
// Datapath of the text terminal writer: screen memory kept as a ring of rows,
// cursor registers, sweep address and the result register.
// ----------------------------------------------------------------------------
module ttw_dp #(
	parameter int COLS = ttw_pkg::DEF_COLS,
	parameter int ROWS = ttw_pkg::DEF_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ttw_pkg::in_item_t   in_data,
	input  ttw_pkg::cmd_t       cmd,
	output ttw_pkg::status_t    status,
	input  logic [7:0]          cell_attribute,
	output logic                out_valid,
	input  logic                out_ready,
	output ttw_pkg::out_item_t  out_data
);

	localparam int CELLS = ROWS * COLS;
	localparam int CW    = $clog2(COLS);
	localparam int RW    = $clog2(ROWS);
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = ((AW > 11) ? AW : 11) + 1;

	logic [7:0] mem [CELLS];
	logic [7:0] mem_rd_q;

	ttw_pkg::in_item_t  item_q;
	ttw_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] lin_q;
	logic [AW-1:0] rowbase_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] end_q;
	logic          scrolled_q;
	logic [7:0]    rchar_q;
	logic [7:0]    rattr_q;

	logic          newline;
	logic          col_last;
	logic          row_last;
	logic          next_row;
	logic          in_range;
	logic [SW-1:0] log_addr;
	logic [SW-1:0] sum;
	logic [SW-1:0] wrapped;
	logic [AW-1:0] phys;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [63:0]   col_x;
	logic [63:0]   row_x;
	logic [63:0]   lin_x;

	assign newline  = (item_q.char_code == ttw_pkg::CH_LF) ||
	                  (item_q.char_code == ttw_pkg::CH_CR);
	assign col_last = (col_q == CW'(COLS - 1));
	assign row_last = (row_q == RW'(ROWS - 1));
	assign next_row = newline || col_last;
	assign in_range = SW'(item_q.cell_index) < SW'(CELLS);

	// logical cell to physical cell: the top row sits at base_q in the ring
	assign log_addr = (item_q.func == ttw_pkg::FUNC_READ) ? SW'(item_q.cell_index)
	                                                      : SW'(lin_q);
	assign sum      = log_addr + SW'(base_q);
	assign wrapped  = (sum >= SW'(CELLS)) ? (sum - SW'(CELLS)) : sum;
	assign phys     = wrapped[AW-1:0];

	assign we    = (cmd.put && !newline) || cmd.sweep;
	assign waddr = cmd.sweep ? addr_q : phys;
	assign wdata = cmd.sweep ? ttw_pkg::CH_SPACE : item_q.char_code;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_rd_q <= mem[phys];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			lin_q      <= '0;
			rowbase_q  <= '0;
			base_q     <= '0;
			addr_q     <= '0;
			end_q      <= AW'(CELLS - 1);
			scrolled_q <= 1'b0;
			rchar_q    <= '0;
			rattr_q    <= '0;
		end else begin
			if (cmd.take) begin
				scrolled_q <= 1'b0;
				rchar_q    <= '0;
				rattr_q    <= '0;
			end
			if (cmd.put) begin
				if (next_row) begin
					col_q <= '0;
					if (row_last) begin
						// the old top row becomes the blank bottom row
						scrolled_q <= 1'b1;
						lin_q      <= rowbase_q;
						addr_q     <= base_q;
						end_q      <= base_q + AW'(COLS - 1);
						base_q     <= (base_q == AW'(CELLS - COLS)) ? '0
						                                            : base_q + AW'(COLS);
					end else begin
						row_q     <= row_q + RW'(1);
						rowbase_q <= rowbase_q + AW'(COLS);
						lin_q     <= rowbase_q + AW'(COLS);
					end
				end else begin
					col_q <= col_q + CW'(1);
					lin_q <= lin_q + AW'(1);
				end
			end
			if (cmd.sweep) begin
				addr_q <= addr_q + AW'(1);
			end
			if (cmd.clear_start) begin
				col_q     <= '0;
				row_q     <= '0;
				lin_q     <= '0;
				rowbase_q <= '0;
				base_q    <= '0;
				addr_q    <= '0;
				end_q     <= AW'(CELLS - 1);
			end
			if (cmd.capture && in_range) begin
				rchar_q <= mem_rd_q;
				rattr_q <= cell_attribute;
			end
		end
	end

	assign col_x = 64'(col_q);
	assign row_x = 64'(row_q);
	assign lin_x = 64'(lin_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.cursor_column <= col_x[6:0];
			out_q.cursor_row    <= row_x[4:0];
			out_q.cursor_linear <= lin_x[10:0];
			out_q.cursor_update <= ((item_q.func == ttw_pkg::FUNC_PUT) && item_q.last_of_write)
			                       || (item_q.func == ttw_pkg::FUNC_CLEAR);
			out_q.scrolled      <= scrolled_q;
			out_q.cell_char     <= rchar_q;
			out_q.cell_attr     <= rattr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.func       = item_q.func;
	assign status.scroll_req = next_row && row_last;
	assign status.sweep_last = (addr_q == end_q);
	assign status.out_free   = !out_valid_q || out_ready;

`ifndef NO_ASSERTIONS
	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < 32'(COLS)) && (32'(row_q) < 32'(ROWS)))
		else $error("cursor outside the screen");

	a_linear_match: assert property (@(posedge clk) disable iff (!arst_n)
		lin_q == rowbase_q + AW'(col_q))
		else $error("linear cursor out of step with column and row");

	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(base_q) < 32'(CELLS)) && (32'(end_q) < 32'(CELLS)))
		else $error("ring base or sweep end outside the memory");

	a_scroll_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put && status.scroll_req |=> scrolled_q && (addr_q == $past(base_q)))
		else $error("scroll did not start its sweep at the old top row");
`endif

endmodule

@@ design/text_terminal_writer.sv @@
// ----------------------------------------------------------------------------
// text_terminal_writer
// Text-mode console: a ROWS x COLS character screen with cursor, scrolling,
// cell read-back and clear, plus an APB attribute register.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one operation per beat (put byte, read cell,
//   clear screen). Every operation returns exactly one beat on
//   out_valid/out_ready with the cursor after the operation and, for a read,
//   the cell character and attribute.
//   Items are handled one at a time by the sequencer. A put that scrolls
//   blanks the new bottom row one cell a cycle, and a clear blanks the
//   whole screen the same way.
//   Scrolling moves a ring base instead of copying rows.
//   After reset the block blanks the screen with in_ready low; APB writes are
//   taken during that time.
//   A result waits in the output register while out_ready is low; the next
//   beat is accepted meanwhile and its result waits until that register frees.
//   cell_attribute lives at byte address 0; the user must write it only while idle, the block does not enforce this.
// ----------------------------------------------------------------------------
module text_terminal_writer #(
	parameter int COLS = ttw_pkg::DEF_COLS,
	parameter int ROWS = ttw_pkg::DEF_ROWS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ttw_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ttw_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	ttw_pkg::cmd_t    cmd;
	ttw_pkg::status_t status;
	logic [7:0]       attr_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ttw_pkg::ATTR_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == ttw_pkg::REG_ATTR)) begin
			attr_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == ttw_pkg::REG_ATTR) ? {24'd0, attr_q} : 32'd0;

	ttw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ttw_dp #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_data        (in_data),
		.cmd            (cmd),
		.status         (status),
		.cell_attribute (attr_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data)
	);

endmodule

@@ dv/tb_text_terminal_writer.sv @@
// ----------------------------------------------------------------------------
// tb_text_terminal_writer
// Self-checking bench for the text terminal writer. A cycle-free screen and
// cursor mirror predicts each result beat, which is compared field by field
// as it leaves the block. Covers the edge-case operations, a line that ends
// on the last cell, random write calls, reads and clears under
// several idle/stall mixes, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_text_terminal_writer;

	localparam int COLS        = ttw_pkg::DEF_COLS;
	localparam int ROWS        = ttw_pkg::DEF_ROWS;
	localparam int CELLS       = COLS * ROWS;
	localparam int SETTLE      = CELLS + 16;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_SHOWN   = 30;
	localparam int IN_W        = $bits(ttw_pkg::in_item_t);

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	ttw_pkg::in_item_t  in_data  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	ttw_pkg::out_item_t out_data;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [2:0]         paddr   = '0;
	logic [31:0]        pwdata  = '0;
	logic [31:0]        prdata;
	logic               pready;

	text_terminal_writer #(
		.COLS(COLS),
		.ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// screen and cursor mirror
	logic [7:0]         screen_mirror [CELLS];
	int unsigned        cur_col;
	int unsigned        cur_row;
	logic [7:0]         attr_mirror;
	ttw_pkg::out_item_t pending_results[$];

	int send_idle_pct   = 0;
	int ready_stall_pct = 0;
	logic ready_hold    = 1'b0;
	int idle_cycles     = 0;

	int mismatches      = 0;
	int n_sent          = 0;
	int n_checked       = 0;
	int n_puts          = 0;
	int n_reads         = 0;
	int n_offscreen     = 0;
	int n_clears        = 0;
	int n_other         = 0;
	int n_scrolls       = 0;
	int last_cell_wraps = 0;
	int n_attr_writes   = 0;

	function automatic void blank_mirror();
		foreach (screen_mirror[i])
			screen_mirror[i] = ttw_pkg::CH_SPACE;
	endfunction

	// column 0 of the next row, scrolling past the bottom
	function automatic bit next_line();
		cur_col = 0;
		cur_row++;
		if (cur_row >= ROWS) begin
			for (int i = 0; i < CELLS - COLS; i++)
				screen_mirror[i] = screen_mirror[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++)
				screen_mirror[i] = ttw_pkg::CH_SPACE;
			cur_row = ROWS - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic ttw_pkg::out_item_t console_step(ttw_pkg::in_item_t op);
		ttw_pkg::out_item_t res;
		bit                 scr;
		int unsigned        lin;
		res = '0;
		scr = 1'b0;
		case (op.func)
			ttw_pkg::FUNC_PUT: begin
				n_puts++;
				if (op.char_code == ttw_pkg::CH_LF || op.char_code == ttw_pkg::CH_CR) begin
					scr = next_line();
				end else begin
					if (cur_row == ROWS - 1 && cur_col == COLS - 1)
						last_cell_wraps++;
					screen_mirror[cur_row * COLS + cur_col] = op.char_code;
					cur_col++;
					if (cur_col >= COLS)
						scr = next_line();
				end
				res.cursor_update = op.last_of_write;
			end
			ttw_pkg::FUNC_READ: begin
				n_reads++;
				if (op.cell_index < CELLS) begin
					res.cell_char = screen_mirror[op.cell_index];
					res.cell_attr = attr_mirror;
				end else begin
					n_offscreen++;
				end
			end
			ttw_pkg::FUNC_CLEAR: begin
				n_clears++;
				blank_mirror();
				cur_col = 0;
				cur_row = 0;
				res.cursor_update = 1'b1;
			end
			default: n_other++;
		endcase
		if (scr)
			n_scrolls++;
		lin = cur_row * COLS + cur_col;
		res.cursor_column = cur_col[6:0];
		res.cursor_row    = cur_row[4:0];
		res.cursor_linear = lin[10:0];
		res.scrolled      = scr;
		return res;
	endfunction

	function automatic ttw_pkg::in_item_t mk_op(logic [1:0] f, logic [7:0] c,
			logic [10:0] idx, logic l);
		ttw_pkg::in_item_t op;
		op.func          = f;
		op.char_code     = c;
		op.cell_index    = idx;
		op.last_of_write = l;
		return op;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	// valid stays high between back-to-back beats; it only drops on an idle gap
	task automatic send_op(input ttw_pkg::in_item_t op);
		if ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= op;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(console_step(op));
		n_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_attribute(input logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {ttw_pkg::REG_ATTR, 2'b00};
		pwdata  <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		attr_mirror = val;
		n_attr_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		// read back
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {24'h0, attr_mirror})
			report_mismatch($sformatf("attribute read back %h want %h", prdata, attr_mirror));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct   = send_pct;
		ready_stall_pct = stall_pct;
	endtask

	// edge values of every field on a fresh screen, default attribute
	task automatic test_directed();
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'd0, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'hFF, 11'd1999, 1'b1));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'd2000, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'd2047, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_PUT, 8'h00, 11'd0, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_PUT, 8'hFF, 11'd2047, 1'b1));
		send_op(mk_op(ttw_pkg::FUNC_PUT, 8'h41, 11'd0, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'd0, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'd1, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'd2, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_PUT, ttw_pkg::CH_LF, 11'd0, 1'b1));
		send_op(mk_op(ttw_pkg::FUNC_PUT, ttw_pkg::CH_CR, 11'd0, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_NONE, 8'hFF, 11'd2047, 1'b1));
		send_op(mk_op(ttw_pkg::FUNC_NONE, 8'h00, 11'd0, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_PUT, 8'h7F, 11'd5, 1'b1));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'(2 * COLS), 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_CLEAR, 8'hAA, 11'd1234, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'd0, 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_PUT, ttw_pkg::CH_CR, 11'd0, 1'b1));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'd2, 1'b1));
	endtask

	// fill down to the bottom row and end a line on the very last cell
	task automatic test_last_cell();
		send_op(mk_op(ttw_pkg::FUNC_CLEAR, 8'h00, 11'd0, 1'b1));
		for (int i = 0; i < ROWS - 1; i++)
			send_op(mk_op(ttw_pkg::FUNC_PUT, (i % 2) ? ttw_pkg::CH_CR : ttw_pkg::CH_LF,
				11'd0, 1'b0));
		for (int i = 0; i < COLS; i++)
			send_op(mk_op(ttw_pkg::FUNC_PUT, 8'(8'h30 + i % 40), 11'd0, i == COLS - 1));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'(CELLS - 2 * COLS), 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'(CELLS - COLS - 1), 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'(CELLS - COLS), 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'(CELLS - 1), 1'b0));
		send_op(mk_op(ttw_pkg::FUNC_PUT, ttw_pkg::CH_LF, 11'd0, 1'b1));
		send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00, 11'(CELLS - 3 * COLS), 1'b0));
	endtask

	// mostly write calls of random text, plus reads, clears and noise
	task automatic test_random(input int items);
		int stop_at;
		int kind;
		int len;
		int pick;
		logic [7:0] ch;
		logic [IN_W-1:0] raw;
		stop_at = n_sent + items;
		while (n_sent < stop_at) begin
			kind = $urandom_range(99, 0);
			if (kind < 68) begin
				len = $urandom_range(60, 1);
				for (int i = 0; i < len; i++) begin
					pick = $urandom_range(99, 0);
					if (pick < 8)
						ch = $urandom_range(1, 0) ? ttw_pkg::CH_LF : ttw_pkg::CH_CR;
					else if (pick < 20)
						ch = 8'($urandom_range(255, 0));
					else
						ch = 8'($urandom_range(8'h7E, 8'h20));
					send_op(mk_op(ttw_pkg::FUNC_PUT, ch, 11'($urandom_range(2047, 0)),
						i == len - 1));
				end
			end else if (kind < 88) begin
				send_op(mk_op(ttw_pkg::FUNC_READ, 8'($urandom_range(255, 0)),
					11'(($urandom_range(9, 0) == 0) ? $urandom_range(2047, CELLS)
						: $urandom_range(CELLS - 1, 0)),
					1'($urandom_range(1, 0))));
			end else if (kind < 99) begin
				raw = IN_W'($urandom_range((1 << IN_W) - 1, 0));
				send_op(ttw_pkg::in_item_t'(raw));
			end else begin
				send_op(mk_op(ttw_pkg::FUNC_CLEAR, 8'($urandom_range(255, 0)),
					11'($urandom_range(2047, 0)), 1'($urandom_range(1, 0))));
			end
		end
	endtask

	// output held off long enough for the block to fill and drop in_ready
	task automatic test_backpressure();
		fork
			begin
				ready_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				ready_hold <= 1'b0;
			end
		join_none
		for (int i = 0; i < 16; i++) begin
			if (i % 4 == 3)
				send_op(mk_op(ttw_pkg::FUNC_READ, 8'h00,
					11'($urandom_range(CELLS - 1, 0)), 1'b0));
			else
				send_op(mk_op(ttw_pkg::FUNC_PUT, 8'($urandom_range(8'h7E, 8'h20)),
					11'd0, i % 4 == 2));
		end
	endtask

	// result checker and output-side stall
	always @(posedge clk) begin : result_check
		ttw_pkg::out_item_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (out_data.cursor_column !== want.cursor_column)
					report_mismatch($sformatf("cursor_column got %0d want %0d",
						out_data.cursor_column, want.cursor_column));
				if (out_data.cursor_row !== want.cursor_row)
					report_mismatch($sformatf("cursor_row got %0d want %0d",
						out_data.cursor_row, want.cursor_row));
				if (out_data.cursor_linear !== want.cursor_linear)
					report_mismatch($sformatf("cursor_linear got %0d want %0d",
						out_data.cursor_linear, want.cursor_linear));
				if (out_data.cursor_update !== want.cursor_update)
					report_mismatch($sformatf("cursor_update got %b want %b",
						out_data.cursor_update, want.cursor_update));
				if (out_data.scrolled !== want.scrolled)
					report_mismatch($sformatf("scrolled got %b want %b",
						out_data.scrolled, want.scrolled));
				if (out_data.cell_char !== want.cell_char)
					report_mismatch($sformatf("cell_char got %h want %h",
						out_data.cell_char, want.cell_char));
				if (out_data.cell_attr !== want.cell_attr)
					report_mismatch($sformatf("cell_attr got %h want %h",
						out_data.cell_attr, want.cell_attr));
			end
		end
		out_ready <= !ready_hold && ($urandom_range(99, 0) >= ready_stall_pct);
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[text_terminal_writer] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		blank_mirror();
		cur_col     = 0;
		cur_row     = 0;
		attr_mirror = ttw_pkg::ATTR_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_idling(0, 0);
		test_directed();
		drain();
		set_attribute(8'hFF);
		test_last_cell();
		drain();

		set_attribute(8'h00);
		test_random(350);
		drain();

		set_attribute(8'($urandom_range(255, 0)));
		set_idling(80, 0);
		test_random(300);
		drain();

		set_attribute(8'hA5);
		set_idling(0, 80);
		test_random(300);
		drain();

		set_attribute(8'($urandom_range(255, 0)));
		set_idling(13, 13);
		test_random(350);
		drain();

		set_attribute(8'h5A);
		set_idling(0, 0);
		test_backpressure();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (COLS + 16) @(posedge clk);

		$display("ran %0d operations: %0d puts, %0d reads (%0d off screen), %0d clears, %0d unused",
			n_sent, n_puts, n_reads, n_offscreen, n_clears, n_other);
		$display("checked %0d results, %0d scrolls, %0d last-cell wraps, %0d attribute writes",
			n_checked, n_scrolls, last_cell_wraps, n_attr_writes);
		if (mismatches == 0)
			$display("[text_terminal_writer] OK");
		else
			$display("[text_terminal_writer] ERROR");
		$finish;
	end

endmodule
